// File: sv/tbd_pkg.sv
// shared types and constants for the transmit burst detector
package tbd_pkg;

    localparam int TIME_W  = 32;
    localparam int CUR_W   = 18;
    localparam int MAG_W   = 17;
    localparam int VOLT_W  = 16;
    localparam int POWER_W = 33;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_IDX    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_HIGH_IDX = CFG_IDX_W'(1);

    localparam logic [MAG_W-1:0] THRESHOLD_RESET    = MAG_W'(1000);
    localparam logic [MAG_W-1:0] CHARGER_HIGH_RESET = MAG_W'(5000);

    typedef struct packed {
        logic               above;
        logic [MAG_W-1:0]   eff_ma;
        logic [POWER_W-1:0] power_uw;
    } sample_eval_t;

endpackage

// File: sv/tbd_sample_eval.sv
// per-sample burst condition, effective current and power
module tbd_sample_eval
    import tbd_pkg::*;
(
    input  logic [MAG_W-1:0]         threshold_ma,
    input  logic [MAG_W-1:0]         charger_high_ma,
    input  logic signed [CUR_W-1:0]  battery_ma,
    input  logic [VOLT_W-1:0]        battery_mv,
    input  logic signed [CUR_W-1:0]  charger_ma,
    input  logic [VOLT_W-1:0]        charger_mv,
    output sample_eval_t             eval
);

    logic [MAG_W-1:0]   discharge;
    logic [CUR_W-1:0]   chg_neg;
    logic [MAG_W-1:0]   chg_dis;
    logic               chg_is_dis;
    logic               chg_high;
    logic [MAG_W-1:0]   chg_hi_cur;
    logic [MAG_W-1:0]   eff_a;
    logic [MAG_W-1:0]   eff;
    logic [VOLT_W-1:0]  volts;

    always_comb begin
        discharge  = (!battery_ma[CUR_W-1]) ? battery_ma[MAG_W-1:0] : '0;
        chg_is_dis = charger_ma[CUR_W-1];
        chg_neg    = CUR_W'(-charger_ma);
        // most negative input does not fit, clamp to full scale
        if (!chg_is_dis) begin
            chg_dis = '0;
        end else if (chg_neg[CUR_W-1]) begin
            chg_dis = '1;
        end else begin
            chg_dis = chg_neg[MAG_W-1:0];
        end
        chg_high   = !charger_ma[CUR_W-1] && (charger_ma[MAG_W-1:0] > charger_high_ma);
        chg_hi_cur = chg_high ? charger_ma[MAG_W-1:0] : '0;

        eff_a = (chg_dis > discharge) ? chg_dis : discharge;
        eff   = (chg_hi_cur > eff_a) ? chg_hi_cur : eff_a;
        volts = chg_is_dis ? charger_mv : battery_mv;

        eval.above    = (discharge > threshold_ma) || chg_high || (chg_dis > threshold_ma);
        eval.eff_ma   = eff;
        eval.power_uw = POWER_W'(eff) * POWER_W'(volts);
    end

endmodule

// File: sv/tbd_burst_tracker.sv
// burst state, peak tracking and event output register
module tbd_burst_tracker
    import tbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [TIME_W-1:0]    time_s,
    input  sample_eval_t         eval,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TIME_W-1:0]    m_burst_start_s,
    output logic [TIME_W-1:0]    m_burst_end_s,
    output logic [TIME_W-1:0]    m_burst_length_s,
    output logic [MAG_W-1:0]     m_peak_ma,
    output logic [POWER_W-1:0]   m_peak_uw
);

    logic                active_reg;
    logic [TIME_W-1:0]   start_reg;
    logic [MAG_W-1:0]    peak_ma_reg;
    logic [POWER_W-1:0]  peak_uw_reg;
    logic                m_valid_reg;
    logic [TIME_W-1:0]   start_out_reg;
    logic [TIME_W-1:0]   end_out_reg;
    logic [TIME_W-1:0]   length_out_reg;
    logic [MAG_W-1:0]    peak_ma_out_reg;
    logic [POWER_W-1:0]  peak_uw_out_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            start_reg   <= '0;
            peak_ma_reg <= '0;
            peak_uw_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (step) begin
                if (eval.above) begin
                    if (!active_reg) begin
                        active_reg  <= 1'b1;
                        start_reg   <= time_s;
                        peak_ma_reg <= eval.eff_ma;
                        peak_uw_reg <= eval.power_uw;
                    end else if (eval.eff_ma > peak_ma_reg) begin
                        peak_ma_reg <= eval.eff_ma;
                        peak_uw_reg <= eval.power_uw;
                    end
                end else if (active_reg) begin
                    // burst ends, emit one word
                    active_reg      <= 1'b0;
                    m_valid_reg     <= 1'b1;
                    start_out_reg   <= start_reg;
                    end_out_reg     <= time_s;
                    length_out_reg  <= time_s - start_reg;
                    peak_ma_out_reg <= peak_ma_reg;
                    peak_uw_out_reg <= peak_uw_reg;
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_burst_start_s  = start_out_reg;
    assign m_burst_end_s    = end_out_reg;
    assign m_burst_length_s = length_out_reg;
    assign m_peak_ma        = peak_ma_out_reg;
    assign m_peak_uw        = peak_uw_out_reg;

endmodule

// File: sv/transmit_burst_detector_core.sv
// top level of the transmit burst detector
// Takes one power sample per cycle while the input does not stall, and emits one event
// word when a burst ends. A sample is held in an input register and evaluated (compare,
// 17x16 multiply, peak update), and the event for the sample that ends a burst goes into
// the result register. While an event waits in the result register the input register
// can still take one sample, then the input stalls until the event is taken, so the
// sustained rate is one sample per cycle as long as results are taken. The user must
// write thresholds through the cfg port while the block is idle; this is not enforced.
module transmit_burst_detector_core
    import tbd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [TIME_W-1:0]        s_time_s,
    input  logic signed [CUR_W-1:0]  s_battery_ma,
    input  logic [VOLT_W-1:0]        s_battery_mv,
    input  logic signed [CUR_W-1:0]  s_charger_ma,
    input  logic [VOLT_W-1:0]        s_charger_mv,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [TIME_W-1:0]        m_burst_start_s,
    output logic [TIME_W-1:0]        m_burst_end_s,
    output logic [TIME_W-1:0]        m_burst_length_s,
    output logic [MAG_W-1:0]         m_peak_ma,
    output logic [POWER_W-1:0]       m_peak_uw
);

    logic [MAG_W-1:0]          threshold_reg;
    logic [MAG_W-1:0]          charger_high_reg;
    logic                      in_valid_reg;
    logic [TIME_W-1:0]         time_reg;
    logic signed [CUR_W-1:0]   battery_ma_reg;
    logic [VOLT_W-1:0]         battery_mv_reg;
    logic signed [CUR_W-1:0]   charger_ma_reg;
    logic [VOLT_W-1:0]         charger_mv_reg;
    logic                      out_free;
    logic                      step;
    sample_eval_t              eval;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            charger_high_reg <= CHARGER_HIGH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD_IDX:    threshold_reg    <= cfg_wdata[MAG_W-1:0];
                CFG_CHARGER_HIGH_IDX: charger_high_reg <= cfg_wdata[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            time_reg       <= s_time_s;
            battery_ma_reg <= s_battery_ma;
            battery_mv_reg <= s_battery_mv;
            charger_ma_reg <= s_charger_ma;
            charger_mv_reg <= s_charger_mv;
        end
    end

    tbd_sample_eval u_eval (
        .threshold_ma    (threshold_reg),
        .charger_high_ma (charger_high_reg),
        .battery_ma      (battery_ma_reg),
        .battery_mv      (battery_mv_reg),
        .charger_ma      (charger_ma_reg),
        .charger_mv      (charger_mv_reg),
        .eval            (eval)
    );

    tbd_burst_tracker u_tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .time_s           (time_reg),
        .eval             (eval),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_burst_start_s  (m_burst_start_s),
        .m_burst_end_s    (m_burst_end_s),
        .m_burst_length_s (m_burst_length_s),
        .m_peak_ma        (m_peak_ma),
        .m_peak_uw        (m_peak_uw)
    );

endmodule
